// ----- rtl/core/cartridge_bank_controller_assert.svh -----
// Assertion macros used by the cartridge bank controller checker.
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cartridge bank controller check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cartridge bank controller check failed");

`endif

// ----- rtl/core/cbc_pkg.sv -----
// Types and constants of the cartridge bank controller.
`timescale 1ns / 1ps

package cbc_pkg;

  localparam int ClockRegs   = 5;
  localparam int ClkIdxW     = $clog2(ClockRegs);
  localparam int RomAddrBits = 23;
  localparam int RomBankW    = RomAddrBits - 14;
  localparam int RomSizeCap  = RomAddrBits - 15;
  localparam int PhysW       = 23;
  localparam int AddrW       = 16;
  localparam int ByteW       = 8;
  localparam int ApbAddrW    = 4;
  localparam int ApbDataW    = 32;

  localparam logic [3:0] RamEnKey    = 4'hA;
  localparam logic [7:0] ClkBankBase = 8'h08;

  // register indexes on the config port (byte address 4*index)
  localparam logic [1:0] RegKind     = 2'd0;
  localparam logic [1:0] RegRomSize  = 2'd1;
  localparam logic [1:0] RegRamCount = 2'd2;
  localparam logic [1:0] RegClock    = 2'd3;

  typedef enum logic [2:0] {
    TgtOutside = 3'd0,
    TgtRom     = 3'd1,
    TgtRam     = 3'd2,
    TgtImm     = 3'd3,
    TgtReg     = 3'd4,
    TgtDrop    = 3'd5
  } cbc_target_e;

  typedef enum logic [2:0] {
    KindNone = 3'd0,
    KindMbc1 = 3'd1,
    KindMbc2 = 3'd2,
    KindMbc3 = 3'd3,
    KindMbc5 = 3'd4
  } cbc_kind_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] rom_code;
    logic [4:0] ram_cnt;
    logic       clk_present;
  } cbc_cfg_t;

  typedef struct packed {
    logic                  req_type;
    logic [AddrW-1:0]      address;
    logic [ByteW-1:0]      write_data;
  } cbc_req_t;

  typedef struct packed {
    cbc_target_e           target;
    logic [PhysW-1:0]      phys_address;
    logic [ByteW-1:0]      ram_write_data;
    logic [ByteW-1:0]      immediate_data;
    logic                  force_high_nibble;
  } cbc_result_t;

  typedef struct packed {
    logic [RomBankW-1:0]             rom_page;
    logic [7:0]                      ram_page;
    logic                            ram_en;
    logic                            mode;
    logic [7:0]                      latch;
    logic [ClockRegs-1:0][ByteW-1:0] latched;
  } cbc_state_t;

  typedef struct packed {
    logic                rom_page_we;
    logic [RomBankW-1:0] rom_page;
    logic                ram_page_we;
    logic [7:0]          ram_page;
    logic                ram_en_we;
    logic                ram_en;
    logic                mode_we;
    logic                mode;
    logic                latch_we;
    logic [7:0]          latch;
    logic                snap;
    logic                clk_we;
    logic [ClkIdxW-1:0]  clk_idx;
    logic [ByteW-1:0]    clk_data;
  } cbc_upd_t;

endpackage

// ----- rtl/core/cbc_chan_if.sv -----
// Valid/ready channel interfaces for bus accesses and translation results.
`timescale 1ns / 1ps

interface cbc_req_if;
  import cbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [AddrW-1:0]     address;
  logic [ByteW-1:0]     write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

interface cbc_rsp_if;
  import cbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           target;
  logic [PhysW-1:0]     phys_address;
  logic [ByteW-1:0]     ram_write_data;
  logic [ByteW-1:0]     immediate_data;
  logic                 force_high_nibble;

  modport source (output valid, target, phys_address, ram_write_data, immediate_data,
                  force_high_nibble, input ready);
  modport sink   (input valid, target, phys_address, ram_write_data, immediate_data,
                  force_high_nibble, output ready);
endinterface

// ----- rtl/core/cbc_decode.sv -----
// Access decode: result fields and bank register updates for one bus access.
`timescale 1ns / 1ps

module cbc_decode (
  input  cbc_pkg::cbc_cfg_t    cfg_i,
  input  cbc_pkg::cbc_state_t  st_i,
  input  cbc_pkg::cbc_req_t    req_i,
  output cbc_pkg::cbc_result_t res_o,
  output cbc_pkg::cbc_upd_t    upd_o
);
  import cbc_pkg::*;

  function automatic logic [RomBankW-1:0] nz_bank(input logic [RomBankW-1:0] b);
    return (b == '0) ? RomBankW'(1) : b;
  endfunction

  cbc_kind_e           kind;
  logic [3:0]          rom_cap;
  logic [RomBankW-1:0] rom_mask;
  logic [3:0]          ram_bmask;
  logic                has_ram;
  logic [RomBankW-1:0] hi_bits;
  logic [RomBankW-1:0] rom_lo_bank;
  logic [RomBankW-1:0] rom_hi_bank;
  logic [3:0]          ram_page_sel;
  logic [7:0]          clk_off;
  logic                clk_ok;
  logic [ClkIdxW-1:0]  clk_idx;
  logic                wr;
  logic [AddrW-1:0]    a;
  logic [ByteW-1:0]    v;

  always_comb begin
    kind    = (cfg_i.kind > 3'd4) ? KindNone : cbc_kind_e'(cfg_i.kind);
    rom_cap = (cfg_i.rom_code > 4'(RomSizeCap)) ? 4'(RomSizeCap) : cfg_i.rom_code;
    for (int i = 0; i < RomBankW; i++) begin
      rom_mask[i] = (i <= int'(rom_cap));
    end
    if (cfg_i.ram_cnt >= 5'd16)     ram_bmask = 4'hF;
    else if (cfg_i.ram_cnt >= 5'd8) ram_bmask = 4'h7;
    else if (cfg_i.ram_cnt >= 5'd4) ram_bmask = 4'h3;
    else if (cfg_i.ram_cnt >= 5'd2) ram_bmask = 4'h1;
    else                            ram_bmask = 4'h0;
    has_ram = (cfg_i.ram_cnt != 5'd0);
  end

  always_comb begin
    // MBC1 upper ROM bank bits come from the RAM bank register
    hi_bits      = {st_i.ram_page[3:0], 5'b0};
    rom_lo_bank  = (kind == KindMbc1 && st_i.mode) ? (hi_bits & rom_mask) : '0;
    rom_hi_bank  = ((kind == KindMbc1) ? (hi_bits | st_i.rom_page) : st_i.rom_page) & rom_mask;
    ram_page_sel = (kind == KindMbc1 && !st_i.mode) ? 4'h0 : st_i.ram_page[3:0];
    clk_off      = st_i.ram_page - ClkBankBase;
    clk_ok       = cfg_i.clk_present && (clk_off < 8'(ClockRegs));
    clk_idx      = clk_off[ClkIdxW-1:0];
  end

  always_comb begin
    wr    = req_i.req_type;
    a     = req_i.address;
    v     = req_i.write_data;
    res_o = '0;
    res_o.target = TgtOutside;
    upd_o = '0;
    upd_o.rom_page = nz_bank(RomBankW'(v[3:0]));
    upd_o.ram_en   = (v[3:0] == RamEnKey);
    upd_o.latch    = v;
    upd_o.mode     = v[0];
    upd_o.snap     = (st_i.latch == 8'd0) && (v == 8'd1);
    upd_o.clk_idx  = clk_idx;
    upd_o.clk_data = v;

    if (!a[15]) begin
      if (wr) begin
        res_o.target = TgtReg;
        if (kind == KindMbc2) begin
          if (a[14]) res_o.target = TgtDrop;
          else if (a[8]) upd_o.rom_page_we = 1'b1;
          else upd_o.ram_en_we = 1'b1;
        end else begin
          case (a[14:13])
            2'b00: upd_o.ram_en_we = 1'b1;
            2'b01: begin
              upd_o.rom_page_we = 1'b1;
              case (kind)
                KindMbc1: upd_o.rom_page = nz_bank(RomBankW'(v[4:0]));
                KindMbc3: upd_o.rom_page = nz_bank(RomBankW'(v[6:0]));
                KindMbc5: upd_o.rom_page = a[12] ? {v[0], st_i.rom_page[7:0]}
                                                 : {st_i.rom_page[8], v};
                default: begin
                  upd_o.rom_page_we = 1'b0;
                  res_o.target = TgtDrop;
                end
              endcase
            end
            2'b10: begin
              upd_o.ram_page_we = 1'b1;
              case (kind)
                KindMbc1: upd_o.ram_page = {6'b0, v[1:0]};
                KindMbc3: upd_o.ram_page = v;
                KindMbc5: upd_o.ram_page = {4'b0, v[3:0]};
                default: begin
                  upd_o.ram_page_we = 1'b0;
                  res_o.target = TgtDrop;
                end
              endcase
            end
            default: begin
              case (kind)
                KindMbc1: upd_o.mode_we = 1'b1;
                KindMbc3: upd_o.latch_we = 1'b1;
                default: res_o.target = TgtDrop;
              endcase
            end
          endcase
        end
      end else begin
        res_o.target       = TgtRom;
        res_o.phys_address = a[14] ? {rom_hi_bank, a[13:0]} : {rom_lo_bank, a[13:0]};
      end
    end else if (a[15:13] == 3'b101) begin
      if (!st_i.ram_en) begin
        res_o.target         = wr ? TgtDrop : TgtImm;
        res_o.immediate_data = wr ? 8'h00 : 8'hFF;
      end else if (kind == KindMbc2) begin
        res_o.target            = TgtRam;
        res_o.phys_address      = PhysW'(a[8:0]);
        res_o.ram_write_data    = wr ? {4'h0, v[3:0]} : 8'h00;
        res_o.force_high_nibble = !wr;
      end else if (kind == KindMbc3 && st_i.ram_page >= ClkBankBase) begin
        if (clk_ok) begin
          if (wr) begin
            res_o.target = TgtReg;
            upd_o.clk_we = 1'b1;
          end else begin
            res_o.target         = TgtImm;
            res_o.immediate_data = st_i.latched[clk_idx];
          end
        end else begin
          res_o.target         = wr ? TgtDrop : TgtImm;
          res_o.immediate_data = wr ? 8'h00 : 8'hFF;
        end
      end else if (has_ram) begin
        res_o.target         = TgtRam;
        res_o.phys_address   = PhysW'({ram_page_sel & ram_bmask, a[12:0]});
        res_o.ram_write_data = wr ? v : 8'h00;
      end else begin
        res_o.target         = wr ? TgtDrop : TgtImm;
        res_o.immediate_data = wr ? 8'h00 : 8'hFF;
      end
    end
  end

endmodule

// ----- rtl/core/cartridge_bank_controller.sv -----
// Top level of the cartridge bank controller: channels, config port, bank state.
`timescale 1ns / 1ps

// Channel   Dir  Role    Per transfer
// req_i     in   sink    req_type, address, write_data (one CPU bus access)
// rsp_o     out  source  target, phys_address, ram_write_data, immediate_data,
//                        force_high_nibble (one result per access)
// APB       in   slave   config writes/reads, registers at byte address 4*index
//
// Two-stage pipe: an access lands in the input register, is decoded
// combinationally and its result is written to the output register.
// One access per cycle sustained while rsp is not stalled; rsp valid comes
// from the output register, after the access passes the input register.
// Bank registers update as an access moves into the output register, so
// later accesses see earlier writes in order. A stalled rsp holds the output
// register; the input register still takes one access, then req_i.ready drops.
// rst_ni resets config, bank (ROM bank 1) and clock regs, both valid flags.

module cartridge_bank_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cbc_req_if.sink                        req_i,
  cbc_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbc_pkg::ApbAddrW-1:0]   paddr,
  input  logic [cbc_pkg::ApbDataW-1:0]   pwdata,
  output logic [cbc_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);
  import cbc_pkg::*;

  // config registers
  cbc_cfg_t cfg_q;

  // bank and clock state
  logic [RomBankW-1:0]             rom_page_q;
  logic [7:0]                      ram_page_q;
  logic                            ram_en_q;
  logic                            mode_q;
  logic [7:0]                      latch_q;
  logic [ClockRegs-1:0][ByteW-1:0] clk_regs_q;
  logic [ClockRegs-1:0][ByteW-1:0] latched_q;

  // pipe registers
  logic        in_v_q;
  cbc_req_t    req_q;
  logic        out_v_q;
  cbc_result_t res_q;

  cbc_state_t  st;
  cbc_result_t res_d;
  cbc_upd_t    upd;
  logic        adv;
  logic        in_take;
  logic        cfg_wr;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      RegKind:     prdata = ApbDataW'(cfg_q.kind);
      RegRomSize:  prdata = ApbDataW'(cfg_q.rom_code);
      RegRamCount: prdata = ApbDataW'(cfg_q.ram_cnt);
      RegClock:    prdata = ApbDataW'(cfg_q.clk_present);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegKind:     cfg_q.kind        <= pwdata[2:0];
        RegRomSize:  cfg_q.rom_code    <= pwdata[3:0];
        RegRamCount: cfg_q.ram_cnt     <= pwdata[4:0];
        RegClock:    cfg_q.clk_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // decode fires when the output register is free or being emptied
  assign adv         = in_v_q && (!out_v_q || rsp_o.ready);
  assign req_i.ready = !in_v_q || adv;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_take)  in_v_q <= 1'b1;
      else if (adv) in_v_q <= 1'b0;
      if (adv)                  out_v_q <= 1'b1;
      else if (rsp_o.ready)     out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.req_type   <= req_i.req_type;
      req_q.address    <= req_i.address;
      req_q.write_data <= req_i.write_data;
    end
    if (adv) res_q <= res_d;
  end

  // ---------------------------------------------------------------- decode
  assign st.rom_page = rom_page_q;
  assign st.ram_page = ram_page_q;
  assign st.ram_en   = ram_en_q;
  assign st.mode     = mode_q;
  assign st.latch    = latch_q;
  assign st.latched  = latched_q;

  cbc_decode u_decode (
    .cfg_i (cfg_q),
    .st_i  (st),
    .req_i (req_q),
    .res_o (res_d),
    .upd_o (upd)
  );

  // state commits only for the access that moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_page_q <= RomBankW'(1);
      ram_page_q <= '0;
      ram_en_q   <= 1'b0;
      mode_q     <= 1'b0;
      latch_q    <= '0;
      clk_regs_q <= '0;
      latched_q  <= '0;
    end else if (adv) begin
      if (upd.rom_page_we) rom_page_q <= upd.rom_page;
      if (upd.ram_page_we) ram_page_q <= upd.ram_page;
      if (upd.ram_en_we)   ram_en_q   <= upd.ram_en;
      if (upd.mode_we)     mode_q     <= upd.mode;
      if (upd.latch_we) begin
        latch_q <= upd.latch;
        if (upd.snap) latched_q <= clk_regs_q;
      end
      if (upd.clk_we) clk_regs_q[upd.clk_idx] <= upd.clk_data;
    end
  end

  // ---------------------------------------------------------------- output
  assign rsp_o.valid             = out_v_q;
  assign rsp_o.target            = res_q.target;
  assign rsp_o.phys_address      = res_q.phys_address;
  assign rsp_o.ram_write_data    = res_q.ram_write_data;
  assign rsp_o.immediate_data    = res_q.immediate_data;
  assign rsp_o.force_high_nibble = res_q.force_high_nibble;

endmodule

// ----- rtl/core/cbc_checker.sv -----
// Port-level checks of the cartridge bank controller result channel.
`timescale 1ns / 1ps
`include "cartridge_bank_controller_assert.svh"

module cbc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [2:0]                rsp_target_i,
  input logic [cbc_pkg::PhysW-1:0] rsp_phys_i,
  input logic [cbc_pkg::ByteW-1:0] rsp_wdata_i,
  input logic [cbc_pkg::ByteW-1:0] rsp_imm_i,
  input logic                      rsp_force_i
);
  import cbc_pkg::*;

  // stalled result holds all fields but the nibble flag
  `CBC_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_target_i) && $stable(rsp_phys_i) && $stable(rsp_wdata_i) && $stable(rsp_imm_i))

  // write data and nibble flag only on external RAM results
  `CBC_ASSERT_NOW(a_wdata_ram_only, rsp_valid_i && rsp_target_i != TgtRam, rsp_wdata_i == '0 && !rsp_force_i)

  // immediate byte only on immediate results
  `CBC_ASSERT_NOW(a_imm_only, rsp_valid_i && rsp_target_i != TgtImm, rsp_imm_i == '0)

  // physical address only for ROM or RAM
  `CBC_ASSERT_NOW(a_phys_only, rsp_valid_i && rsp_target_i != TgtRom && rsp_target_i != TgtRam, rsp_phys_i == '0)

  // nibble flag marks a RAM read, which carries no write byte
  `CBC_ASSERT_NOW(a_force_read, rsp_valid_i && rsp_force_i, rsp_target_i == TgtRam && rsp_wdata_i == '0)

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_target_i(rsp_o.target),
  .rsp_phys_i  (rsp_o.phys_address),
  .rsp_wdata_i (rsp_o.ram_write_data),
  .rsp_imm_i   (rsp_o.immediate_data),
  .rsp_force_i (rsp_o.force_high_nibble)
);
